// ----- sv/btmx_pkg.sv -----
// Shared request, status and counter definitions for the maximum-XOR trie block.
`timescale 1ns / 1ps

package btmx_pkg;

  // Width of the per-node occupancy counter and its saturation value.
  localparam int OCC_W = 20;
  localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

  // Request codes carried on the request channel.
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_QUERY  = 2'd3
  } req_t;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POOL_FULL  = 2'd1,
    ST_KEY_ABSENT = 2'd2,
    ST_SET_EMPTY  = 2'd3
  } status_t;

endpackage

// ----- sv/btmx_req_if.sv -----
// Request channel interface: operation code and key with a valid/ready handshake.
`timescale 1ns / 1ps

interface btmx_req_if #(
  parameter int KEY_BITS = 31
) ();
  logic                  valid;
  logic                  ready;
  btmx_pkg::req_t        req_type;
  logic [KEY_BITS-1:0]   key;

  modport source (output valid, req_type, key, input ready);
  modport sink   (input valid, req_type, key, output ready);
endinterface

// ----- sv/btmx_rsp_if.sv -----
// Result channel interface: maximum XOR value and status with a valid/ready handshake.
`timescale 1ns / 1ps

interface btmx_rsp_if #(
  parameter int KEY_BITS = 31
) ();
  logic                  valid;
  logic                  ready;
  logic [KEY_BITS-1:0]   max_xor;
  btmx_pkg::status_t     status;

  modport source (output valid, max_xor, status, input ready);
  modport sink   (input valid, max_xor, status, output ready);
endinterface

// ----- sv/btmx_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module btmx_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/binary_trie_max_xor_multiset_unit.sv -----
// Top level: multiset of keys in a binary trie with insert, remove, clear and max-XOR query.
//
//   Channel  Dir  Payload                     Handshake
//   req      in   req_type[1:0], key          valid/ready, one request per transaction
//   rsp      out  max_xor, status[1:0]        valid/ready, one result per transaction
//
// One request is worked at a time; every trie level costs one or more accesses to the node
// RAM (one registered read port, one write port). Clear writes an empty root; insert does
// one read-modify-write per level; remove makes a checking walk, then a decrementing walk;
// query reads the opposite child first, the same-bit child only when the opposite one is
// empty. Reset is synchronous; after it,
// an empty root is written before requests are taken.
// A new request is taken while the previous result still waits in the output register.
`timescale 1ns / 1ps

module binary_trie_max_xor_multiset_unit #(
  parameter int KEY_BITS   = 31,
  parameter int NODE_COUNT = 65536
) (
  input  logic         clk,
  input  logic         rst,
  btmx_req_if.sink     req,
  btmx_rsp_if.source   rsp
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int REC_W  = 2 * NODE_W + btmx_pkg::OCC_W;
  localparam logic [NODE_W:0]  NODE_TOP  = (NODE_W + 1)'(NODE_COUNT);
  localparam logic [NODE_W:0]  POOL_NEED = (NODE_W + 1)'(KEY_BITS);
  localparam logic [LVL_W-1:0] LVL_TOP   = LVL_W'(KEY_BITS - 1);

  // One trie node as stored in the RAM.
  typedef struct packed {
    logic [NODE_W-1:0]           one;
    logic [NODE_W-1:0]           zero;
    logic [btmx_pkg::OCC_W-1:0]  occ;
  } node_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR,
    S_INS,
    S_RMV_FIND,
    S_RMV_DEC,
    S_Q_ROOT,
    S_Q_OPP,
    S_Q_CHKO,
    S_Q_CHKS,
    S_DONE
  } state_t;

  state_t              state;
  logic [KEY_BITS-1:0] key_q;
  logic [LVL_W-1:0]    lvl;
  logic                at_leaf;
  logic                hold;
  node_t               cur;
  logic [NODE_W-1:0]   cur_addr;
  logic [NODE_W:0]     nfn;
  logic [KEY_BITS-1:0] res;
  btmx_pkg::status_t   st;
  logic                out_valid;
  logic [KEY_BITS-1:0] out_xor;
  btmx_pkg::status_t   out_status;

  // RAM port signals.
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic [REC_W-1:0]  rd_data;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  node_t             wr_node;

  node_t             rd_node;
  node_t             nd;
  logic              bit_b;
  logic [NODE_W-1:0] nd_child;
  logic [NODE_W-1:0] nd_opp;
  logic [NODE_W-1:0] cur_same;
  logic [NODE_W-1:0] new_node;
  logic              pool_short;
  logic              root_full;
  logic              accept;

  btmx_ram #(
    .WIDTH (REC_W),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (REC_W'(wr_node)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Current node comes from the RAM unless it was just allocated and is held locally.
  assign rd_node    = node_t'(rd_data);
  assign nd         = hold ? cur : rd_node;
  assign bit_b      = key_q[lvl];
  assign nd_child   = bit_b ? nd.one : nd.zero;
  assign nd_opp     = bit_b ? nd.zero : nd.one;
  assign cur_same   = bit_b ? cur.one : cur.zero;
  assign new_node   = nfn[NODE_W-1:0];
  assign pool_short = (NODE_TOP - nfn) < POOL_NEED;
  assign root_full  = (cur_addr == '0) && (nd.occ == btmx_pkg::OCC_MAX);
  assign accept     = req.valid && req.ready;

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.max_xor = out_xor;
  assign rsp.status  = out_status;

  // RAM access control for each step of the walk.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = cur_addr;
    wr_node = nd;
    unique case (state)
      S_INIT, S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_node = '0;
      end
      S_IDLE: begin
        rd_en = accept;
      end
      S_INS: begin
        if (!root_full) begin
          wr_en       = 1'b1;
          wr_node.occ = nd.occ + 1'b1;
          if (!at_leaf) begin
            if (nd_child == '0) begin
              if (bit_b) begin
                wr_node.one = new_node;
              end else begin
                wr_node.zero = new_node;
              end
            end else begin
              rd_en   = 1'b1;
              rd_addr = nd_child;
            end
          end
        end
      end
      S_RMV_FIND: begin
        if (!at_leaf && nd_child != '0) begin
          rd_en   = 1'b1;
          rd_addr = nd_child;
        end else if (at_leaf && nd.occ != '0) begin
          rd_en = 1'b1;
        end
      end
      S_RMV_DEC: begin
        wr_en       = 1'b1;
        wr_node.occ = nd.occ - 1'b1;
        if (!at_leaf) begin
          rd_en   = 1'b1;
          rd_addr = nd_child;
        end
      end
      S_Q_OPP: begin
        if (nd_opp != '0) begin
          rd_en   = 1'b1;
          rd_addr = nd_opp;
        end else if (nd_child != '0) begin
          rd_en   = 1'b1;
          rd_addr = nd_child;
        end
      end
      S_Q_CHKO: begin
        if (rd_node.occ == '0 && cur_same != '0) begin
          rd_en   = 1'b1;
          rd_addr = cur_same;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, walk registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
      nfn       <= (NODE_W + 1)'(1);
      hold      <= 1'b0;
      at_leaf   <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            key_q    <= req.key;
            lvl      <= LVL_TOP;
            at_leaf  <= 1'b0;
            hold     <= 1'b0;
            cur_addr <= '0;
            res      <= '0;
            st       <= (req.req_type == btmx_pkg::REQ_INSERT && pool_short) ?
                        btmx_pkg::ST_POOL_FULL : btmx_pkg::ST_OK;
            unique case (req.req_type)
              btmx_pkg::REQ_CLEAR: state <= S_CLR;
              btmx_pkg::REQ_INSERT: begin
                if (pool_short) begin
                  state <= S_DONE;
                end else begin
                  state <= S_INS;
                end
              end
              btmx_pkg::REQ_REMOVE: state <= S_RMV_FIND;
              btmx_pkg::REQ_QUERY:  state <= S_Q_ROOT;
            endcase
          end
        end
        S_CLR: begin
          nfn   <= (NODE_W + 1)'(1);
          state <= S_DONE;
        end
        // Insert: bump each node on the path, allocating missing children.
        S_INS: begin
          if (root_full) begin
            st    <= btmx_pkg::ST_POOL_FULL;
            state <= S_DONE;
          end else if (at_leaf) begin
            hold  <= 1'b0;
            state <= S_DONE;
          end else begin
            if (nd_child == '0) begin
              nfn      <= nfn + 1'b1;
              cur      <= '0;
              hold     <= 1'b1;
              cur_addr <= new_node;
            end else begin
              hold     <= 1'b0;
              cur_addr <= nd_child;
            end
            if (lvl == '0) begin
              at_leaf <= 1'b1;
            end else begin
              lvl <= lvl - 1'b1;
            end
          end
        end
        // Remove, first pass: confirm the full path exists and the leaf is occupied.
        S_RMV_FIND: begin
          if (at_leaf) begin
            if (nd.occ == '0) begin
              st    <= btmx_pkg::ST_KEY_ABSENT;
              state <= S_DONE;
            end else begin
              cur_addr <= '0;
              lvl      <= LVL_TOP;
              at_leaf  <= 1'b0;
              state    <= S_RMV_DEC;
            end
          end else if (nd_child == '0) begin
            st    <= btmx_pkg::ST_KEY_ABSENT;
            state <= S_DONE;
          end else begin
            cur_addr <= nd_child;
            if (lvl == '0) begin
              at_leaf <= 1'b1;
            end else begin
              lvl <= lvl - 1'b1;
            end
          end
        end
        // Remove, second pass: decrement every node on the path.
        S_RMV_DEC: begin
          if (at_leaf) begin
            state <= S_DONE;
          end else begin
            cur_addr <= nd_child;
            if (lvl == '0) begin
              at_leaf <= 1'b1;
            end else begin
              lvl <= lvl - 1'b1;
            end
          end
        end
        S_Q_ROOT: begin
          if (rd_node.occ == '0) begin
            st    <= btmx_pkg::ST_SET_EMPTY;
            state <= S_DONE;
          end else begin
            state <= S_Q_OPP;
          end
        end
        // Query: probe the opposite child first, then the same-bit child.
        S_Q_OPP: begin
          cur <= nd;
          if (nd_opp != '0) begin
            state <= S_Q_CHKO;
          end else if (nd_child != '0) begin
            state <= S_Q_CHKS;
          end else begin
            state <= S_DONE;
          end
        end
        S_Q_CHKO: begin
          if (rd_node.occ != '0) begin
            res[lvl] <= 1'b1;
            if (lvl == '0) begin
              state <= S_DONE;
            end else begin
              lvl   <= lvl - 1'b1;
              state <= S_Q_OPP;
            end
          end else if (cur_same != '0) begin
            state <= S_Q_CHKS;
          end else begin
            state <= S_DONE;
          end
        end
        S_Q_CHKS: begin
          if (rd_node.occ != '0 && lvl != '0) begin
            lvl   <= lvl - 1'b1;
            state <= S_Q_OPP;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_xor    <= res;
            out_status <= st;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A node is never written and read in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("node RAM read and write hit the same entry");

  // Allocation stays inside the node pool.
  a_alloc_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && wr_en && !at_leaf && nd_child == '0) |-> (nfn < NODE_TOP))
    else $error("node allocated beyond the pool");

  // The pool counter never passes the pool size.
  a_nfn_range: assert property (@(posedge clk) disable iff (rst)
    (nfn != '0) && (nfn <= NODE_TOP))
    else $error("next free node out of range");

  // A nonzero XOR value is only reported with an ok status.
  a_xor_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == btmx_pkg::ST_OK || out_xor == '0))
    else $error("nonzero max_xor reported with an error status");
`endif

endmodule
